>>> hw/rtl/atccf_pkg.sv
// ----------------------------------------------------------------------------
// atccf_pkg
// shared constants and controller/datapath interface types for the adc
// trigger command chain sequencer
// ----------------------------------------------------------------------------
package atccf_pkg;

  localparam int FifoDepth    = 16;
  localparam int TriggerCount = 8;
  localparam int RegWords     = 256;
  localparam int ChannelCount = 32;

  localparam int FAW = $clog2(FifoDepth);
  localparam int RAW = $clog2(RegWords);

  // item kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_HWTRG = 2'd2;
  localparam logic [1:0] KIND_CODE  = 2'd3;

  // register word indexes
  localparam logic [7:0] W_VERID    = 8'd0;
  localparam logic [7:0] W_CTRL     = 8'd4;
  localparam logic [7:0] W_STAT     = 8'd5;
  localparam logic [7:0] W_IE       = 8'd6;
  localparam logic [7:0] W_SWTRIG   = 8'd13;
  localparam logic [7:0] W_TCTRL    = 8'd40;
  localparam logic [7:0] W_FCTRL0   = 8'd56;
  localparam logic [7:0] W_FCTRL1   = 8'd57;
  localparam logic [7:0] W_GCR0     = 8'd62;
  localparam logic [7:0] W_GCR1     = 8'd63;
  localparam logic [7:0] W_CMD_BASE = 8'd62;  // 64 + 2*(cmd-1) = 62 + 2*cmd
  localparam logic [7:0] W_RESFIFO0 = 8'd192;
  localparam logic [7:0] W_RESFIFO1 = 8'd193;

  localparam logic [31:0] VERID_VALUE = 32'h0209_0000;
  localparam logic [31:0] GCR_CAL     = 32'h0101_0000;
  localparam logic [15:0] CODE_MID    = 16'h8000;
  localparam logic [5:0]  MAX_STEPS   = 6'd32;

  typedef struct packed {
    logic load;       // latch the request
    logic dec_rd;     // read issue at decode
    logic rd_cap;     // capture bus read result, pop if fifo
    logic wr_exec;    // perform a non-trigger bus write
    logic code_set;   // channel code update
    logic tsel;       // pick next software trigger, read its tctrl
    logic hw_start;   // start a hardware trigger chain
    logic tw_start;   // start a software trigger chain
    logic chk_rd;     // read cmdl of current command
    logic lw;         // capture channel, read cmdh
    logic hw2;        // capture loop count and next command
    logic push;       // push one entry
    logic tdone;      // chain complete
    logic irq_upd;    // re-evaluate ready bits and irq
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       is_swtrig;
    logic       is_irq_reg;
    logic       is_pop;
    logic       hw_go;
    logic       ctrl_en;
    logic       mask_zero;
    logic       chain_end;
    logic       loop_last;
  } dp_stat_t;

endpackage

>>> hw/rtl/atccf_ram.sv
// ----------------------------------------------------------------------------
// atccf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module atccf_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/atccf_ctrl.sv
// ----------------------------------------------------------------------------
// atccf_ctrl
// sequencer state machine: decodes requests and walks trigger chains
// ----------------------------------------------------------------------------
module atccf_ctrl import atccf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RDW   = 4'd2;
  localparam logic [3:0] S_HWW   = 4'd3;
  localparam logic [3:0] S_TSEL  = 4'd4;
  localparam logic [3:0] S_TW    = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_LW    = 4'd7;
  localparam logic [3:0] S_HW2   = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;
  localparam logic [3:0] S_TDONE = 4'd10;
  localparam logic [3:0] S_IRQ   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (st.kind)
          KIND_READ: begin
            cmd.dec_rd = 1'b1;
            state_nxt  = S_RDW;
          end
          KIND_WRITE: begin
            if (st.is_swtrig) begin
              state_nxt = S_TSEL;
            end else begin
              cmd.wr_exec = 1'b1;
              state_nxt   = st.is_irq_reg ? S_IRQ : S_OUT;
            end
          end
          KIND_HWTRG: begin
            cmd.dec_rd = 1'b1;
            state_nxt  = S_HWW;
          end
          default: begin
            cmd.code_set = 1'b1;
            state_nxt    = S_OUT;
          end
        endcase
      end
      S_RDW: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = st.is_pop ? S_IRQ : S_OUT;
      end
      S_HWW: begin
        if (st.hw_go) begin
          cmd.hw_start = 1'b1;
          state_nxt    = S_CHK;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_TSEL: begin
        if (st.mask_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.tsel  = 1'b1;
          state_nxt = S_TW;
        end
      end
      S_TW: begin
        if (st.ctrl_en) begin
          cmd.tw_start = 1'b1;
          state_nxt    = S_CHK;
        end else begin
          state_nxt = S_TSEL;
        end
      end
      S_CHK: begin
        if (st.chain_end) begin
          state_nxt = S_TDONE;
        end else begin
          cmd.chk_rd = 1'b1;
          state_nxt  = S_LW;
        end
      end
      S_LW: begin
        cmd.lw    = 1'b1;
        state_nxt = S_HW2;
      end
      S_HW2: begin
        cmd.hw2   = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (st.loop_last) begin
          state_nxt = S_CHK;
        end
      end
      S_TDONE: begin
        cmd.tdone = 1'b1;
        state_nxt = st.is_swtrig ? S_TSEL : S_OUT;
      end
      S_IRQ: begin
        cmd.irq_upd = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/atccf_dp.sv
// ----------------------------------------------------------------------------
// atccf_dp
// register file, result fifos, channel codes and chain walking datapath
// ----------------------------------------------------------------------------
module atccf_dp import atccf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    st,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_word_addr,
  input  logic [31:0] in_write_data,
  input  logic [2:0]  in_trigger_line,
  input  logic        in_trigger_level,
  input  logic [4:0]  in_channel,
  input  logic [15:0] in_sample_code,
  output logic [31:0] out_read_data,
  output logic        out_irq
);

  // latched request
  logic [1:0]  kind_r;
  logic [7:0]  addr_r;
  logic [31:0] data_r;
  logic [2:0]  line_r;
  logic        level_r;
  logic [4:0]  ch_r;
  logic [15:0] scode_r;

  // dedicated registers
  logic [31:0] ctrl_r, ctrl_nxt, stat_r, stat_nxt, ie_r, ie_nxt;
  logic [31:0] fctrl_r [2];
  logic [31:0] gcr_r   [2];
  logic [FAW-1:0] head_r [2];
  logic [FAW:0]   cnt_r  [2];
  logic           irq_r;
  logic [31:0]    rd_r;
  logic [15:0]    codes_r [ChannelCount];
  logic [RegWords-1:0] vld_r;
  logic                vld_q;

  // chain walking
  logic [2:0]  t_r;
  logic [3:0]  cur_r, ncmd_r, loops_r, l_r;
  logic [5:0]  steps_r;
  logic [15:0] code_r;
  logic [7:0]  mask_r;

  logic [RAW-1:0] reg_raddr;
  logic [31:0]    reg_q, reg_eff;
  logic           reg_we;
  logic [FAW:0]   fifo_raddr, fifo_waddr;
  logic [31:0]    fifo_q, fifo_wdata;
  logic           fifo_we;
  logic [2:0]     tsel_idx;
  logic           pop_f;
  logic [FAW-1:0] push_slot;
  logic [31:0]    rd_val;
  logic           rdy0, rdy1;

  assign reg_eff = vld_q ? reg_q : 32'd0;
  assign pop_f   = addr_r[0];

  // lowest pending software trigger
  always_comb begin
    tsel_idx = 3'd0;
    for (int i = TriggerCount - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        tsel_idx = 3'(i);
      end
    end
  end

  always_comb begin
    reg_raddr = addr_r;
    if (cmd.dec_rd && kind_r == KIND_HWTRG) begin
      reg_raddr = W_TCTRL + {5'd0, line_r};
    end else if (cmd.tsel) begin
      reg_raddr = W_TCTRL + {5'd0, tsel_idx};
    end else if (cmd.chk_rd) begin
      reg_raddr = W_CMD_BASE + {3'd0, cur_r, 1'b0};
    end else if (cmd.lw) begin
      reg_raddr = W_CMD_BASE + {3'd0, cur_r, 1'b1};
    end
  end

  assign reg_we = cmd.wr_exec && !(addr_r == W_CTRL || addr_r == W_STAT || addr_r == W_IE ||
                  addr_r == W_FCTRL0 || addr_r == W_FCTRL1 ||
                  addr_r == W_GCR0 || addr_r == W_GCR1);

  atccf_ram #(.Width(32), .Depth(RegWords)) u_reg_ram (
    .clk   (clk),
    .we    (reg_we),
    .waddr (addr_r),
    .wdata (data_r),
    .raddr (reg_raddr),
    .rdata (reg_q)
  );

  assign push_slot  = FAW'(head_r[0] + cnt_r[0][FAW-1:0]);
  assign fifo_waddr = {1'b0, push_slot};
  assign fifo_raddr = {pop_f, head_r[pop_f]};
  assign fifo_we    = cmd.push && (cnt_r[0] < (FAW+1)'(FifoDepth));
  assign fifo_wdata = {1'b1, 7'd0, l_r, 1'b0, t_r, code_r};

  atccf_ram #(.Width(32), .Depth(2 * FifoDepth)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (fifo_raddr),
    .rdata (fifo_q)
  );

  // bus read result
  always_comb begin
    case (addr_r)
      W_VERID:    rd_val = VERID_VALUE;
      W_CTRL:     rd_val = ctrl_r;
      W_STAT:     rd_val = stat_r;
      W_IE:       rd_val = ie_r;
      W_FCTRL0:   rd_val = {fctrl_r[0][31:5], cnt_r[0]};
      W_FCTRL1:   rd_val = {fctrl_r[1][31:5], cnt_r[1]};
      W_GCR0:     rd_val = gcr_r[0];
      W_GCR1:     rd_val = gcr_r[1];
      W_RESFIFO0: rd_val = (cnt_r[0] == '0) ? 32'd0 : fifo_q;
      W_RESFIFO1: rd_val = (cnt_r[1] == '0) ? 32'd0 : fifo_q;
      default:    rd_val = reg_eff;
    endcase
  end

  assign rdy0 = cnt_r[0] > {1'b0, fctrl_r[0][19:16]};
  assign rdy1 = cnt_r[1] > {1'b0, fctrl_r[1][19:16]};

  // status back to the controller
  assign st.kind       = kind_r;
  assign st.is_swtrig  = (kind_r == KIND_WRITE) && (addr_r == W_SWTRIG);
  assign st.is_irq_reg = (addr_r == W_CTRL) || (addr_r == W_STAT) || (addr_r == W_IE);
  assign st.is_pop     = (addr_r == W_RESFIFO0) || (addr_r == W_RESFIFO1);
  assign st.hw_go      = level_r && reg_eff[0] && ctrl_r[0];
  assign st.ctrl_en    = ctrl_r[0];
  assign st.mask_zero  = (mask_r == 8'd0);
  assign st.chain_end  = (cur_r == 4'd0) || (steps_r == MAX_STEPS);
  assign st.loop_last  = (l_r == loops_r);

  // dedicated register next values
  always_comb begin
    ctrl_nxt = ctrl_r;
    stat_nxt = stat_r;
    ie_nxt   = ie_r;
    if (cmd.wr_exec) begin
      case (addr_r)
        W_CTRL: begin
          ctrl_nxt = data_r & ~32'h0000_030A;
          if (data_r[1]) stat_nxt = 32'd0;
          if (data_r[3]) stat_nxt = stat_nxt | 32'h0000_0400;
        end
        W_STAT:  stat_nxt = stat_r & ~(data_r & 32'h0000_020A);
        W_IE:    ie_nxt   = data_r;
        default: ;
      endcase
    end
    if (cmd.push && !fifo_we) stat_nxt = stat_r | 32'h0000_0002;
    if (cmd.tdone)   stat_nxt = (stat_r & ~32'd5) | {29'd0, rdy1, 1'b0, rdy0} | 32'h0000_0200;
    if (cmd.irq_upd) stat_nxt = (stat_r & ~32'd5) | {29'd0, rdy1, 1'b0, rdy0};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      addr_r  <= in_word_addr;
      data_r  <= in_write_data;
      line_r  <= in_trigger_line;
      level_r <= in_trigger_level;
      ch_r    <= in_channel;
      scode_r <= in_sample_code;
    end
    vld_q <= vld_r[reg_raddr];
    if (cmd.hw_start || cmd.tw_start) begin
      cur_r   <= reg_eff[27:24];
      steps_r <= 6'd0;
    end
    if (cmd.lw) begin
      code_r <= codes_r[reg_eff[4:0]];
    end
    if (cmd.hw2) begin
      loops_r <= reg_eff[19:16];
      ncmd_r  <= reg_eff[27:24];
      l_r     <= 4'd0;
    end
    if (cmd.push) begin
      l_r <= l_r + 4'd1;
      if (l_r == loops_r) begin
        cur_r   <= ncmd_r;
        steps_r <= steps_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= '0;
      stat_r  <= '0;
      ie_r    <= '0;
      irq_r   <= 1'b0;
      rd_r    <= '0;
      mask_r  <= '0;
      t_r     <= '0;
      vld_r   <= '0;
      for (int f = 0; f < 2; f++) begin
        fctrl_r[f] <= '0;
        gcr_r[f]   <= '0;
        head_r[f]  <= '0;
        cnt_r[f]   <= '0;
      end
      for (int c = 0; c < ChannelCount; c++) begin
        codes_r[c] <= CODE_MID;
      end
    end else begin
      ctrl_r <= ctrl_nxt;
      stat_r <= stat_nxt;
      ie_r   <= ie_nxt;
      if (cmd.load) begin
        rd_r <= '0;
        if (in_kind == KIND_WRITE && in_word_addr == W_SWTRIG) begin
          mask_r <= in_write_data[7:0];
        end
      end
      if (reg_we) begin
        vld_r[addr_r] <= 1'b1;
      end
      if (cmd.wr_exec) begin
        case (addr_r)
          W_CTRL: begin
            if (data_r[1] || data_r[8]) begin
              head_r[0] <= '0;
              cnt_r[0]  <= '0;
            end
            if (data_r[1] || data_r[9]) begin
              head_r[1] <= '0;
              cnt_r[1]  <= '0;
            end
            if (data_r[3]) begin
              gcr_r[0] <= GCR_CAL;
              gcr_r[1] <= GCR_CAL;
            end
          end
          W_FCTRL0: fctrl_r[0] <= data_r;
          W_FCTRL1: fctrl_r[1] <= data_r;
          W_GCR0:   gcr_r[0]   <= data_r;
          W_GCR1:   gcr_r[1]   <= data_r;
          default: ;
        endcase
      end
      if (cmd.code_set) begin
        codes_r[ch_r] <= scode_r;
      end
      if (cmd.rd_cap) begin
        rd_r <= rd_val;
        if (st.is_pop && cnt_r[pop_f] != '0) begin
          head_r[pop_f] <= head_r[pop_f] + 1'b1;
          cnt_r[pop_f]  <= cnt_r[pop_f] - 1'b1;
        end
      end
      if (cmd.hw_start) begin
        t_r <= line_r;
      end
      if (cmd.tsel) begin
        t_r            <= tsel_idx;
        mask_r[tsel_idx] <= 1'b0;
      end
      if (fifo_we) begin
        cnt_r[0] <= cnt_r[0] + 1'b1;
      end
      if (cmd.tdone || cmd.irq_upd) begin
        irq_r <= (rdy0 && ie_r[0]) || (rdy1 && ie_r[2]);
      end
    end
  end

  assign out_read_data = rd_r;
  assign out_irq       = irq_r;

endmodule

>>> hw/rtl/adc_trigger_command_chain_fifo_top.sv
// ----------------------------------------------------------------------------
// adc_trigger_command_chain_fifo_top
// register-mapped adc sequencer with trigger command chains and result fifos
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with out_valid high, and the
// receiver cannot stall it. register reads go through the registered
// register-file ram. a trigger walks its command chain one command at a time:
// the chk, lw and hw2 states fetch cmdl and cmdh, then the push state writes
// one fifo entry per loop (1 to 16 entries per command), for at most 32
// commands per chain; a software trigger write runs each selected trigger in
// turn. busy stays high until the result shows.
// ----------------------------------------------------------------------------
module adc_trigger_command_chain_fifo_top import atccf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_word_addr,
  input  logic [31:0] in_write_data,
  input  logic [2:0]  in_trigger_line,
  input  logic        in_trigger_level,
  input  logic [4:0]  in_channel,
  input  logic [15:0] in_sample_code,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic        out_irq
);

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t st;

  atccf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  // register file, fifos, channel codes and irq live here
  atccf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_kind          (in_kind),
    .in_word_addr     (in_word_addr),
    .in_write_data    (in_write_data),
    .in_trigger_line  (in_trigger_line),
    .in_trigger_level (in_trigger_level),
    .in_channel       (in_channel),
    .in_sample_code   (in_sample_code),
    .out_read_data    (out_read_data),
    .out_irq          (out_irq)
  );

endmodule

>>> hw/rtl/atccf_checker.sv
// ----------------------------------------------------------------------------
// atccf_checker
// port-level checks of the request/result sequencing
// ----------------------------------------------------------------------------
module atccf_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // result strobe is a single cycle
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // an accepted request makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request accepted without busy");

  // a result only appears while a request is in flight
  a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without request");

  // busy drops only right after a result
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> $past(out_valid)) else $error("busy dropped early");

endmodule

bind adc_trigger_command_chain_fifo_top atccf_checker u_atccf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives bus reads, bus writes, hardware trigger changes and channel code
// updates into the adc sequencer and checks every result against a predictor
// of the register file, the result fifos, the command chains and the irq
// ----------------------------------------------------------------------------
module testbench;
  import atccf_pkg::*;

  // ctrl / stat bit masks used by the predictor and the stimulus
  localparam logic [31:0] CTRL_ENABLE    = 32'h0000_0001;
  localparam logic [31:0] CTRL_SOFTRESET = 32'h0000_0002;
  localparam logic [31:0] CTRL_CAL       = 32'h0000_0008;
  localparam logic [31:0] CTRL_RSTF0     = 32'h0000_0100;
  localparam logic [31:0] CTRL_RSTF1     = 32'h0000_0200;
  localparam logic [31:0] STAT_READY0    = 32'h0000_0001;
  localparam logic [31:0] STAT_OVERFLOW0 = 32'h0000_0002;
  localparam logic [31:0] STAT_READY1    = 32'h0000_0004;
  localparam logic [31:0] STAT_W1C       = 32'h0000_020A;
  localparam logic [31:0] STAT_TCOMP     = 32'h0000_0200;
  localparam logic [31:0] STAT_CALR      = 32'h0000_0400;
  localparam int          LIMIT          = 20_000_000;

  typedef struct packed {
    logic [31:0] rd;
    logic        irq;
  } result_t;

  // ------------------------------------------------------------------------
  // sequencer predictor plus the store of expected results
  // ------------------------------------------------------------------------
  class seq_scoreboard;
    logic [31:0] regs[RegWords];
    logic [31:0] store[2*FifoDepth];
    int          head[2];
    int          count[2];
    logic [15:0] codes[ChannelCount];
    logic        irq;
    result_t     pending[$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (store[i]) store[i] = '0;
      foreach (codes[i]) codes[i] = CODE_MID;
      head = '{0, 0};
      count = '{0, 0};
      irq = 1'b0;
      errors = 0;
    endfunction

    function void eval_irq();
      logic [31:0] rdy;
      logic [31:0] ie;
      rdy = '0;
      ie = regs[W_IE];
      if (count[0] > int'(regs[W_FCTRL0][19:16])) rdy |= STAT_READY0;
      if (count[1] > int'(regs[W_FCTRL1][19:16])) rdy |= STAT_READY1;
      regs[W_STAT] = (regs[W_STAT] & ~(STAT_READY0 | STAT_READY1)) | rdy;
      irq = |(rdy & ie & (STAT_READY0 | STAT_READY1));
    endfunction

    function void push_entry(logic [31:0] e);
      if (count[0] >= FifoDepth) begin
        regs[W_STAT] |= STAT_OVERFLOW0;
        return;
      end
      store[(head[0] + count[0]) % FifoDepth] = e;
      count[0]++;
    endfunction

    function logic [31:0] pop_entry(int f);
      logic [31:0] v;
      if (count[f] == 0) return '0;
      v = store[f*FifoDepth + head[f]];
      head[f] = (head[f] + 1) % FifoDepth;
      count[f]--;
      return v;
    endfunction

    function void walk_chain(int t);
      int          cmd;
      int          steps;
      logic [31:0] cmdh;
      logic [4:0]  ch;
      logic [15:0] code;
      if (!regs[W_CTRL][0]) return;
      steps = 0;
      cmd = int'(regs[W_TCTRL + t][27:24]);
      while (cmd != 0 && steps < MAX_STEPS) begin
        cmdh = regs[W_CMD_BASE + 2*cmd + 1];
        ch = regs[W_CMD_BASE + 2*cmd][4:0];
        code = (ch < ChannelCount) ? codes[ch] : CODE_MID;
        steps++;
        for (int l = 0; l <= int'(cmdh[19:16]); l++)
          push_entry(32'h8000_0000 | (t << 16) | (l << 20) | code);
        cmd = int'(cmdh[27:24]);
      end
      regs[W_STAT] |= STAT_TCOMP;
      eval_irq();
    endfunction

    function logic [31:0] bus_read(logic [7:0] a);
      logic [31:0] v;
      if (a == W_VERID) return VERID_VALUE;
      if (a == W_RESFIFO0 || a == W_RESFIFO1) begin
        v = pop_entry(int'(a - W_RESFIFO0));
        eval_irq();
        return v;
      end
      if (a == W_FCTRL0 || a == W_FCTRL1)
        return (regs[a] & ~32'h1F) | count[a - W_FCTRL0];
      return regs[a];
    endfunction

    function void bus_write(logic [7:0] a, logic [31:0] v);
      case (a)
        W_CTRL: begin
          if (v & CTRL_SOFTRESET) begin
            head = '{0, 0};
            count = '{0, 0};
            regs[W_STAT] = '0;
          end
          if (v & CTRL_RSTF0) begin head[0] = 0; count[0] = 0; end
          if (v & CTRL_RSTF1) begin head[1] = 0; count[1] = 0; end
          if (v & CTRL_CAL) begin
            regs[W_STAT] |= STAT_CALR;
            regs[W_GCR0] = GCR_CAL;
            regs[W_GCR1] = GCR_CAL;
          end
          regs[W_CTRL] = v & ~(CTRL_SOFTRESET | CTRL_RSTF0 | CTRL_RSTF1 | CTRL_CAL);
          eval_irq();
        end
        W_STAT: begin
          regs[W_STAT] &= ~(v & STAT_W1C);
          eval_irq();
        end
        W_SWTRIG: begin
          for (int t = 0; t < TriggerCount; t++)
            if (v[t]) walk_chain(t);
        end
        W_IE: begin
          regs[W_IE] = v;
          eval_irq();
        end
        default: regs[a] = v;
      endcase
    endfunction

    // note one accepted request and queue its expected result
    function void note_request(logic [1:0] kind, logic [7:0] addr, logic [31:0] data,
                               logic [2:0] line, logic lvl, logic [4:0] ch,
                               logic [15:0] code);
      result_t r;
      r.rd = '0;
      case (kind)
        KIND_READ:  r.rd = bus_read(addr);
        KIND_WRITE: bus_write(addr, data);
        KIND_HWTRG: if (lvl && line < TriggerCount && regs[W_TCTRL + line][0])
                      walk_chain(int'(line));
        default:    if (ch < ChannelCount) codes[ch] = code;
      endcase
      r.irq = irq;
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] rd, logic irq_out);
      result_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: read_data %h irq %b", rd, irq_out);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (rd !== e.rd) begin
        $error("read_data expected %h actual %h", e.rd, rd);
        errors++;
      end
      if (irq_out !== e.irq) begin
        $error("irq expected %b actual %b", e.irq, irq_out);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [7:0]  in_word_addr;
  logic [31:0] in_write_data;
  logic [2:0]  in_trigger_line;
  logic        in_trigger_level;
  logic [4:0]  in_channel;
  logic [15:0] in_sample_code;
  logic        out_valid;
  logic [31:0] out_read_data;
  logic        out_irq;

  seq_scoreboard sb = new();
  int            cycles = 0;
  int            sent = 0;

  adc_trigger_command_chain_fifo_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_word_addr(in_word_addr), .in_write_data(in_write_data),
    .in_trigger_line(in_trigger_line), .in_trigger_level(in_trigger_level),
    .in_channel(in_channel), .in_sample_code(in_sample_code),
    .out_valid(out_valid), .out_read_data(out_read_data), .out_irq(out_irq)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // results cannot be held off, so every strobe is checked right away
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_read_data, out_irq);
  end

  // present one request and hold it until taken; unused fields get noise
  task automatic issue(logic [1:0] kind, logic [7:0] addr, logic [31:0] data,
                       logic [2:0] line, logic lvl, logic [4:0] ch, logic [15:0] code);
    start            <= 1'b1;
    in_kind          <= kind;
    in_word_addr     <= addr;
    in_write_data    <= data;
    in_trigger_line  <= line;
    in_trigger_level <= lvl;
    in_channel       <= ch;
    in_sample_code   <= code;
    do @(posedge clk); while (busy);
    sb.note_request(kind, addr, data, line, lvl, ch, code);
    sent++;
    // random idle gap, skipped in the long no-idle stretch
    if ((sent < 300 || sent > 450) && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic bus_rd(logic [7:0] a);
    issue(KIND_READ, a, $urandom, 3'($urandom), 1'($urandom), 5'($urandom),
          16'($urandom));
  endtask

  task automatic bus_wr(logic [7:0] a, logic [31:0] d);
    issue(KIND_WRITE, a, d, 3'($urandom), 1'($urandom), 5'($urandom), 16'($urandom));
  endtask

  task automatic hw_trig(logic [2:0] line, logic lvl);
    issue(KIND_HWTRG, 8'($urandom), $urandom, line, lvl, 5'($urandom), 16'($urandom));
  endtask

  task automatic set_code(logic [4:0] ch, logic [15:0] code);
    issue(KIND_CODE, 8'($urandom), $urandom, 3'($urandom), 1'($urandom), ch, code);
  endtask

  // write a random command: short loops mostly, any next pointer
  task automatic program_cmd(int c);
    logic [31:0] cmdh;
    cmdh = $urandom;
    cmdh[19:16] = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2));
    if ($urandom_range(3) != 0) cmdh[27:24] = 4'($urandom_range(15));
    bus_wr(8'(W_CMD_BASE + 2*c), $urandom);
    bus_wr(8'(W_CMD_BASE + 2*c + 1), cmdh);
  endtask

  // well-formed pass: program commands, arm a trigger, fire it, drain fifo0
  task automatic chain_pass();
    int          t;
    logic [31:0] tctrl;
    t = $urandom_range(TriggerCount - 1);
    repeat ($urandom_range(1, 4)) program_cmd($urandom_range(1, 15));
    if ($urandom_range(2) == 0) set_code(5'($urandom), 16'($urandom));
    tctrl = $urandom;
    tctrl[27:24] = 4'($urandom_range(15));
    tctrl[0] = ($urandom_range(3) != 0);
    bus_wr(8'(W_TCTRL + t), tctrl);
    if ($urandom_range(1)) hw_trig(3'(t), 1'b1);
    else bus_wr(W_SWTRIG, (32'h1 << t) | ($urandom_range(7) == 0 ? $urandom : 32'h0));
    repeat ($urandom_range(0, 18)) bus_rd(W_RESFIFO0);
  endtask

  // noise and odd accesses
  task automatic noise_item();
    logic [31:0] d;
    case ($urandom_range(11))
      0: bus_rd(8'($urandom));
      1: bus_wr(8'($urandom_range(64, 191)), $urandom);
      2: bus_rd($urandom_range(1) ? W_STAT : 8'(W_FCTRL0 + $urandom_range(1)));
      3: bus_rd(8'(W_RESFIFO0 + $urandom_range(1)));
      4: begin
        d = $urandom;
        d[0] = ($urandom_range(7) != 0);
        d[1] = ($urandom_range(15) == 0);
        bus_wr(W_CTRL, d);
      end
      5: bus_wr(W_STAT, $urandom);
      6: bus_wr(W_IE, $urandom);
      7: bus_wr(8'(W_FCTRL0 + $urandom_range(1)), $urandom);
      8: hw_trig(3'($urandom), 1'($urandom));
      9: set_code(5'($urandom), 16'($urandom));
      10: bus_wr(8'($urandom_range(14, 39)), $urandom);
      default: bus_wr(W_SWTRIG, $urandom_range(1) ? $urandom : 32'h1 << $urandom_range(7));
    endcase
  endtask

  initial begin
    start            <= 1'b0;
    in_kind          <= '0;
    in_word_addr     <= '0;
    in_write_data    <= '0;
    in_trigger_line  <= '0;
    in_trigger_level <= 1'b0;
    in_channel       <= '0;
    in_sample_code   <= '0;
    rst_n            <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: id, storage, calibration, overflow, w1c, fifo resets, disabled adc
    bus_rd(W_VERID);
    bus_wr(8'd255, 32'hFFFF_FFFF);
    bus_rd(8'd255);
    bus_wr(W_IE, STAT_READY0 | STAT_READY1);
    bus_wr(W_FCTRL0, 32'h0003_0000);
    bus_wr(W_CTRL, CTRL_ENABLE | CTRL_CAL);
    bus_rd(W_GCR0);
    set_code(5'd0, 16'hFFFF);
    set_code(5'd31, 16'h0000);
    bus_wr(W_CMD_BASE + 8'd2, 32'h0000_0000);
    bus_wr(W_CMD_BASE + 8'd3, 32'h020F_0000);
    bus_wr(W_CMD_BASE + 8'd4, 32'h0000_001F);
    bus_wr(W_CMD_BASE + 8'd5, 32'h0000_0000);
    bus_wr(W_TCTRL, 32'h0100_0001);
    hw_trig(3'd0, 1'b0);
    hw_trig(3'd0, 1'b1);
    bus_wr(W_SWTRIG, 32'h0000_0001);
    bus_rd(W_STAT);
    bus_rd(W_FCTRL0);
    bus_rd(W_RESFIFO0);
    bus_rd(W_RESFIFO1);
    bus_wr(W_STAT, STAT_W1C);
    bus_wr(W_CTRL, CTRL_ENABLE | CTRL_RSTF0 | CTRL_RSTF1);
    bus_wr(W_CTRL, CTRL_SOFTRESET);
    bus_wr(W_SWTRIG, 32'hFFFF_FFFF);

    // random: chain passes with noise mixed in
    bus_wr(W_CTRL, CTRL_ENABLE);
    while (sent < 820) begin
      if ($urandom_range(2) != 0) chain_pass();
      else noise_item();
      if (sent > 400 && sent < 420) begin
        // hold off until the block has caught up
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        @(posedge clk);
      end
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/atccf_pkg.sv
hw/rtl/atccf_ram.sv
hw/rtl/atccf_ctrl.sv
hw/rtl/atccf_dp.sv
hw/rtl/adc_trigger_command_chain_fifo_top.sv
hw/rtl/atccf_checker.sv
sim/testbench.sv
